[src/rig_pkg.sv]
// shared widths, register indexes and defaults for the rotated image address generator
package rig_pkg;

	localparam int COORD_W    = 10;
	localparam int SIZE_W     = 11;
	localparam int STRIDE_W   = 13;
	localparam int COEF_W     = 16;
	localparam int OFFSET_W   = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_SIZE_DEF  = 1024;
	localparam int FRAC_BITS_DEF = 14;

	// start to done, in cycles
	localparam int PIPE_LAT = 6;

	localparam logic [SIZE_W-1:0]   AREA_SIZE_RST   = SIZE_W'(256);
	localparam logic [STRIDE_W-1:0] SRC_STRIDE_RST  = STRIDE_W'(256);
	localparam logic [STRIDE_W-1:0] DEST_STRIDE_RST = STRIDE_W'(256);
	localparam logic [COEF_W-1:0]   ROT_COS_RST     = COEF_W'(16384);
	localparam logic [COEF_W-1:0]   ROT_NEGSIN_RST  = COEF_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AREA_SIZE   = 3'd0,
		REG_SRC_STRIDE  = 3'd1,
		REG_DEST_STRIDE = 3'd2,
		REG_ROT_COS     = 3'd3,
		REG_ROT_NEGSIN  = 3'd4
	} cfg_reg_t;

endpackage

[src/rotated_image_address_generator.sv]
// inverse-rotation source address generator, six-stage pipeline
// a transfer accepted on start runs through stages s1 to s6, and done rises with its result
// from the stage 6 output registers
// throughput: one destination pixel per cycle, every cycle; busy is always low
// the receiver cannot stall, so nothing in the pipeline ever waits
// reset: arst_n low clears all valid bits at once and loads the register defaults
// (size 256, both strides 256, cos 1.0, negated sine 0)
module rotated_image_address_generator #(
	parameter int FRAC_BITS = rig_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rig_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rig_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic [rig_pkg::COORD_W-1:0]        dest_col,
	input  logic [rig_pkg::COORD_W-1:0]        dest_row,
	// result side
	output logic                               done,
	output logic                               copy_enable,
	output logic [rig_pkg::COORD_W-1:0]        src_col,
	output logic [rig_pkg::COORD_W-1:0]        src_row,
	output logic [rig_pkg::OFFSET_W-1:0]       src_offset,
	output logic [rig_pkg::OFFSET_W-1:0]       dest_offset
);

	// centered coordinate: column minus half the size, one sign bit wider
	localparam int OFS_W   = rig_pkg::COORD_W + 1;
	// one rotation product
	localparam int PROD_W  = OFS_W + rig_pkg::COEF_W;
	// sum of two products plus the fixed-point center, with headroom
	localparam int CFIX_W  = rig_pkg::COORD_W + FRAC_BITS + 1;
	localparam int SUM_W   = ((PROD_W + 1 > CFIX_W) ? PROD_W + 1 : CFIX_W) + 1;
	// integer part of the magnitude after truncation
	localparam int QUO_W   = SUM_W - FRAC_BITS;
	localparam int DPROD_W = rig_pkg::COORD_W + rig_pkg::STRIDE_W;
	localparam int SPROD_W = rig_pkg::SIZE_W + rig_pkg::STRIDE_W;

	// ---------------------------------------------------------------
	// configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
	// ---------------------------------------------------------------
	logic        [rig_pkg::SIZE_W-1:0]   area_size_q;
	logic        [rig_pkg::STRIDE_W-1:0] src_stride_q;
	logic        [rig_pkg::STRIDE_W-1:0] dest_stride_q;
	logic signed [rig_pkg::COEF_W-1:0]   rot_cos_q;
	logic signed [rig_pkg::COEF_W-1:0]   rot_negsin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_size_q   <= rig_pkg::AREA_SIZE_RST;
			src_stride_q  <= rig_pkg::SRC_STRIDE_RST;
			dest_stride_q <= rig_pkg::DEST_STRIDE_RST;
			rot_cos_q     <= rig_pkg::ROT_COS_RST;
			rot_negsin_q  <= rig_pkg::ROT_NEGSIN_RST;
		end else if (cfg_we) begin
			case (rig_pkg::cfg_reg_t'(cfg_index))
				rig_pkg::REG_AREA_SIZE: begin
					area_size_q <= cfg_wdata[rig_pkg::SIZE_W-1:0];
				end
				rig_pkg::REG_SRC_STRIDE: begin
					src_stride_q <= cfg_wdata[rig_pkg::STRIDE_W-1:0];
				end
				rig_pkg::REG_DEST_STRIDE: begin
					dest_stride_q <= cfg_wdata[rig_pkg::STRIDE_W-1:0];
				end
				rig_pkg::REG_ROT_COS: begin
					rot_cos_q <= cfg_wdata[rig_pkg::COEF_W-1:0];
				end
				rig_pkg::REG_ROT_NEGSIN: begin
					rot_negsin_q <= cfg_wdata[rig_pkg::COEF_W-1:0];
				end
				default: begin
					// unmapped index, write is dropped
				end
			endcase
		end
	end

	// no back-pressure anywhere: a new transfer is taken every cycle
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// valid bits, one per stage
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: clamp the size, center the coordinates, start the
	// destination offset multiply
	// ---------------------------------------------------------------
	logic [rig_pkg::SIZE_W-1:0]  size_c;
	logic [rig_pkg::COORD_W-1:0] half_c;

	always_comb begin
		// sizes above the supported maximum behave as the maximum
		if (32'(area_size_q) > rig_pkg::MAX_SIZE_DEF) begin
			size_c = rig_pkg::SIZE_W'(rig_pkg::MAX_SIZE_DEF);
		end else begin
			size_c = area_size_q;
		end
		half_c = size_c[rig_pkg::SIZE_W-1:1];
	end

	logic signed [OFS_W-1:0]       ox_s1, oy_s1;
	logic        [rig_pkg::SIZE_W-1:0]  size_s1;
	logic        [rig_pkg::COORD_W-1:0] half_s1;
	logic        [rig_pkg::COORD_W-1:0] dcol_s1;
	logic        [DPROD_W-1:0]     dprod_s1;

	always_ff @(posedge clk) begin
		ox_s1    <= $signed({1'b0, dest_col}) - $signed({1'b0, half_c});
		oy_s1    <= $signed({1'b0, dest_row}) - $signed({1'b0, half_c});
		size_s1  <= size_c;
		half_s1  <= half_c;
		dcol_s1  <= dest_col;
		dprod_s1 <= DPROD_W'(dest_row) * DPROD_W'(dest_stride_q);
	end

	// ---------------------------------------------------------------
	// stage 2: the four rotation products, center in fixed point,
	// destination offset finished
	// ---------------------------------------------------------------
	logic signed [PROD_W-1:0] p_xc_s2, p_yn_s2, p_xn_s2, p_yc_s2;
	logic signed [SUM_W-1:0]  cfix_s2;
	logic [rig_pkg::SIZE_W-1:0]   size_s2;
	logic [rig_pkg::OFFSET_W-1:0] doff_s2;
	logic [DPROD_W-1:0]           dsum_c;

	assign dsum_c = dprod_s1 + DPROD_W'(dcol_s1);

	always_ff @(posedge clk) begin
		p_xc_s2 <= ox_s1 * rot_cos_q;
		p_yn_s2 <= oy_s1 * rot_negsin_q;
		p_xn_s2 <= ox_s1 * rot_negsin_q;
		p_yc_s2 <= oy_s1 * rot_cos_q;
		cfix_s2 <= $signed(SUM_W'(half_s1) << FRAC_BITS);
		size_s2 <= size_s1;
		doff_s2 <= dsum_c[rig_pkg::OFFSET_W-1:0];
	end

	// ---------------------------------------------------------------
	// stage 3: source coordinates in fixed point
	// sx = x*cos + y*nsin + c, sy = -x*nsin + y*cos + c
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0]      sx_fix_s3, sy_fix_s3;
	logic [rig_pkg::SIZE_W-1:0]   size_s3;
	logic [rig_pkg::OFFSET_W-1:0] doff_s3;

	always_ff @(posedge clk) begin
		sx_fix_s3 <= SUM_W'(p_xc_s2) + SUM_W'(p_yn_s2) + cfix_s2;
		sy_fix_s3 <= SUM_W'(p_yc_s2) - SUM_W'(p_xn_s2) + cfix_s2;
		size_s3   <= size_s2;
		doff_s3   <= doff_s2;
	end

	// ---------------------------------------------------------------
	// stage 4: truncate toward zero and bounds check
	// a value in (-1, 0) truncates to zero and still counts as inside
	// ---------------------------------------------------------------
	logic             x_neg, y_neg;
	logic [SUM_W-1:0] x_mag, y_mag;
	logic [QUO_W-1:0] x_int, y_int;
	logic             x_in, y_in, inside_c;

	always_comb begin
		x_neg    = sx_fix_s3[SUM_W-1];
		y_neg    = sy_fix_s3[SUM_W-1];
		x_mag    = x_neg ? SUM_W'(-sx_fix_s3) : SUM_W'(sx_fix_s3);
		y_mag    = y_neg ? SUM_W'(-sy_fix_s3) : SUM_W'(sy_fix_s3);
		x_int    = x_mag[SUM_W-1:FRAC_BITS];
		y_int    = y_mag[SUM_W-1:FRAC_BITS];
		x_in     = (!x_neg || (x_int == '0)) && (x_int < QUO_W'(size_s3));
		y_in     = (!y_neg || (y_int == '0)) && (y_int < QUO_W'(size_s3));
		inside_c = x_in && y_in;
	end

	logic                         inside_s4;
	logic [rig_pkg::SIZE_W-1:0]   sx_s4, sy_s4;
	logic [rig_pkg::OFFSET_W-1:0] doff_s4;

	always_ff @(posedge clk) begin
		inside_s4 <= inside_c;
		// outside pixels carry zero coordinates so the offset comes out zero
		sx_s4     <= inside_c ? x_int[rig_pkg::SIZE_W-1:0] : '0;
		sy_s4     <= inside_c ? y_int[rig_pkg::SIZE_W-1:0] : '0;
		doff_s4   <= doff_s3;
	end

	// ---------------------------------------------------------------
	// stage 5: source row times stride
	// ---------------------------------------------------------------
	logic                         inside_s5;
	logic [rig_pkg::SIZE_W-1:0]   sx_s5, sy_s5;
	logic [SPROD_W-1:0]           sprod_s5;
	logic [rig_pkg::OFFSET_W-1:0] doff_s5;

	always_ff @(posedge clk) begin
		inside_s5 <= inside_s4;
		sx_s5     <= sx_s4;
		sy_s5     <= sy_s4;
		sprod_s5  <= SPROD_W'(sy_s4) * SPROD_W'(src_stride_q);
		doff_s5   <= doff_s4;
	end

	// ---------------------------------------------------------------
	// stage 6: output registers, offsets wrap at the port width
	// ---------------------------------------------------------------
	logic [SPROD_W-1:0]           ssum_c;
	logic                         inside_s6;
	logic [rig_pkg::COORD_W-1:0]  scol_s6, srow_s6;
	logic [rig_pkg::OFFSET_W-1:0] soff_s6, doff_s6;

	assign ssum_c = sprod_s5 + SPROD_W'(sx_s5);

	always_ff @(posedge clk) begin
		inside_s6 <= inside_s5;
		scol_s6   <= sx_s5[rig_pkg::COORD_W-1:0];
		srow_s6   <= sy_s5[rig_pkg::COORD_W-1:0];
		soff_s6   <= ssum_c[rig_pkg::OFFSET_W-1:0];
		doff_s6   <= doff_s5;
	end

	assign done        = valid_s6;
	assign copy_enable = inside_s6;
	assign src_col     = scol_s6;
	assign src_row     = srow_s6;
	assign src_offset  = soff_s6;
	assign dest_offset = doff_s6;

endmodule

[src/rig_checker.sv]
// port-level checks for the rotated image address generator and its bind
module rig_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         copy_enable,
	input logic [rig_pkg::COORD_W-1:0]  src_col,
	input logic [rig_pkg::COORD_W-1:0]  src_row,
	input logic [rig_pkg::OFFSET_W-1:0] src_offset
);

	// every result traces back to a transfer a fixed latency earlier
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rig_pkg::PIPE_LAT))
		else $error("result without a matching start");

	// back-to-back transfers come out back to back
	a_results_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy, rig_pkg::PIPE_LAT - 1)) |=> done)
		else $error("result of consecutive transfers lost");

	// a pixel that is not copied reports zero source fields
	a_no_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !copy_enable) |-> (src_col == '0 && src_row == '0 && src_offset == '0))
		else $error("source fields not cleared for a skipped pixel");

	// with a zero row and column the source offset must be zero too
	a_origin_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && copy_enable && src_col == '0 && src_row == '0) |-> (src_offset == '0))
		else $error("nonzero offset for source origin");

endmodule

bind rotated_image_address_generator rig_checker u_rig_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.copy_enable (copy_enable),
	.src_col     (src_col),
	.src_row     (src_row),
	.src_offset  (src_offset)
);

[sim/rotated_image_address_generator_tb.sv]
// self-checking testbench for the rotated image address generator
`timescale 1ns / 100ps

module rotated_image_address_generator_tb;
	import rig_pkg::*;

	// run limit in clock cycles, far above the slowest correct run
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 200;

	// one expected mapping, field for field as the result ports carry it
	typedef struct {
		logic                copy;
		logic [COORD_W-1:0]  src_col;
		logic [COORD_W-1:0]  src_row;
		logic [OFFSET_W-1:0] src_off;
		logic [OFFSET_W-1:0] dest_off;
	} pixel_map_t;

	// keeps its own register copy, predicts each mapping and checks the results in order
	class pixel_map_checker;
		logic [SIZE_W-1:0]        area_size;
		logic [STRIDE_W-1:0]      src_stride;
		logic [STRIDE_W-1:0]      dest_stride;
		logic signed [COEF_W-1:0] rot_cos;
		logic signed [COEF_W-1:0] rot_negsin;
		pixel_map_t               pending_maps[$];
		int                       errors;

		function new();
			area_size   = AREA_SIZE_RST;
			src_stride  = SRC_STRIDE_RST;
			dest_stride = DEST_STRIDE_RST;
			rot_cos     = ROT_COS_RST;
			rot_negsin  = ROT_NEGSIN_RST;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_AREA_SIZE:   area_size   = SIZE_W'(data);
				REG_SRC_STRIDE:  src_stride  = STRIDE_W'(data);
				REG_DEST_STRIDE: dest_stride = STRIDE_W'(data);
				REG_ROT_COS:     rot_cos     = data;
				REG_ROT_NEGSIN:  rot_negsin  = data;
				default: ;
			endcase
		endfunction

		// rotate the destination pixel back about the center, truncate toward zero
		function pixel_map_t map_back(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			pixel_map_t m;
			longint     size, ctr, ox, oy, cs, ns, acc_x, acc_y, sx, sy, unit;
			size = longint'(area_size);
			if (size > MAX_SIZE_DEF)
				size = MAX_SIZE_DEF;
			ctr   = size / 2;
			unit  = longint'(1) << FRAC_BITS_DEF;
			ox    = longint'(col) - ctr;
			oy    = longint'(row) - ctr;
			cs    = longint'(rot_cos);
			ns    = longint'(rot_negsin);
			acc_x = ox * cs + oy * ns + ctr * unit;
			acc_y = -(ox * ns) + oy * cs + ctr * unit;
			// integer division truncates toward zero
			sx    = acc_x / unit;
			sy    = acc_y / unit;
			m.copy = (sx >= 0 && sy >= 0 && sx < size && sy < size);
			if (m.copy) begin
				m.src_col = COORD_W'(sx);
				m.src_row = COORD_W'(sy);
				m.src_off = OFFSET_W'(sy * longint'(src_stride) + sx);
			end else begin
				m.src_col = '0;
				m.src_row = '0;
				m.src_off = '0;
			end
			m.dest_off = OFFSET_W'(longint'(row) * longint'(dest_stride) + longint'(col));
			return m;
		endfunction

		function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			pending_maps.push_back(map_back(col, row));
		endfunction

		function int pending();
			return pending_maps.size();
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		endtask

		task check_mapping(logic copy, logic [COORD_W-1:0] sc, logic [COORD_W-1:0] sr,
				logic [OFFSET_W-1:0] so, logic [OFFSET_W-1:0] doff);
			pixel_map_t want;
			if (pending_maps.size() == 0) begin
				report("result with no transfer waiting, copy_enable", copy, 0);
				return;
			end
			want = pending_maps.pop_front();
			if (copy !== want.copy)
				report("copy_enable", copy, want.copy);
			if (sc !== want.src_col)
				report("src_col", sc, want.src_col);
			if (sr !== want.src_row)
				report("src_row", sr, want.src_row);
			if (so !== want.src_off)
				report("src_offset", so, want.src_off);
			if (doff !== want.dest_off)
				report("dest_offset", doff, want.dest_off);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  start;
	logic                  busy;
	logic [COORD_W-1:0]    dest_col;
	logic [COORD_W-1:0]    dest_row;
	logic                  done;
	logic                  copy_enable;
	logic [COORD_W-1:0]    src_col;
	logic [COORD_W-1:0]    src_row;
	logic [OFFSET_W-1:0]   src_offset;
	logic [OFFSET_W-1:0]   dest_offset;

	pixel_map_checker sb;
	int               cycles;
	// when set the sender never idles
	bit               steady;

	rotated_image_address_generator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.dest_col    (dest_col),
		.dest_row    (dest_row),
		.done        (done),
		.copy_enable (copy_enable),
		.src_col     (src_col),
		.src_row     (src_row),
		.src_offset  (src_offset),
		.dest_offset (dest_offset)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung pipeline or a lost result ends here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// monitor: sees pre-edge values, since all inputs move on the falling edge
	// the result is checked before the same-edge transfer is noted, so a stray
	// done can never pair with a fresh expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_mapping(copy_enable, src_col, src_row, src_offset, dest_offset);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_wdata);
			if (start && !busy)
				sb.note_pixel(dest_col, dest_row);
		end
	end

	// present one pixel and hold it until the transfer; start stays high on return
	// so back-to-back pixels never drop it within a time step
	task send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		start    <= 1'b1;
		dest_col <= col;
		dest_row <= row;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// sender gap with junk on the coordinate ports
	task idle_cycles(int n);
		start    <= 1'b0;
		dest_col <= COORD_W'($urandom);
		dest_row <= COORD_W'($urandom);
		repeat (n) @(negedge clk);
	endtask

	// stop sending and wait until every predicted mapping has come back,
	// then let the pipeline run dry
	task drain();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	// register writes only with the pipeline empty; cfg_we is lowered once at the end
	task set_config(logic [SIZE_W-1:0] size, logic [STRIDE_W-1:0] s_str,
			logic [STRIDE_W-1:0] d_str, logic [COEF_W-1:0] cs, logic [COEF_W-1:0] ns);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_AREA_SIZE;
		cfg_wdata <= CFG_DATA_W'(size);
		@(negedge clk);
		cfg_index <= REG_SRC_STRIDE;
		cfg_wdata <= CFG_DATA_W'(s_str);
		@(negedge clk);
		cfg_index <= REG_DEST_STRIDE;
		cfg_wdata <= CFG_DATA_W'(d_str);
		@(negedge clk);
		cfg_index <= REG_ROT_COS;
		cfg_wdata <= cs;
		@(negedge clk);
		cfg_index <= REG_ROT_NEGSIN;
		cfg_wdata <= ns;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function logic [STRIDE_W-1:0] pick_stride();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2:       return STRIDE_W'(1);
			default: return STRIDE_W'($urandom_range(1, 4096));
		endcase
	endfunction

	function logic [COEF_W-1:0] pick_extreme_coef();
		case ($urandom_range(4))
			0:       return COEF_W'(16384);
			1:       return COEF_W'(-16384);
			2:       return 16'h8000;
			3:       return 16'h7fff;
			default: return '0;
		endcase
	endfunction

	// a random register setting, mostly true rotations inside a sane image
	task random_config();
		logic [SIZE_W-1:0] size;
		logic [COEF_W-1:0] cs, ns;
		real               ang;
		case ($urandom_range(9))
			0:       size = '0;
			1:       size = SIZE_W'(1);
			2:       size = SIZE_W'(2);
			3:       size = SIZE_W'(MAX_SIZE_DEF);
			4:       size = '1;
			5:       size = SIZE_W'($urandom_range(MAX_SIZE_DEF + 1, 2047));
			default: size = SIZE_W'($urandom_range(3, MAX_SIZE_DEF));
		endcase
		case ($urandom_range(7))
			0: begin
				cs = COEF_W'($urandom);
				ns = COEF_W'($urandom);
			end
			1: begin
				cs = pick_extreme_coef();
				ns = pick_extreme_coef();
			end
			default: begin
				ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
				cs  = COEF_W'(int'($cos(ang) * 16384.0));
				ns  = COEF_W'(int'(-$sin(ang) * 16384.0));
			end
		endcase
		set_config(size, pick_stride(), pick_stride(), cs, ns);
	endtask

	// mostly pixels inside the image so that copies happen, the rest anywhere
	task random_pixel();
		int lim;
		lim = (sb.area_size > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(sb.area_size);
		if (lim > 0 && $urandom_range(99) < 75)
			send_pixel(COORD_W'($urandom_range(0, lim - 1)), COORD_W'($urandom_range(0, lim - 1)));
		else
			send_pixel(COORD_W'($urandom), COORD_W'($urandom));
	endtask

	initial begin
		sb        = new();
		cycles    = 0;
		steady    = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_AREA_SIZE;
		cfg_wdata = '0;
		start     = 1'b0;
		dest_col  = '0;
		dest_row  = '0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// register defaults: identity rotation of a 256 image
		send_pixel(0, 0);
		send_pixel(255, 255);
		send_pixel(128, 5);
		// destination beyond the area, mapped the same way and out
		send_pixel(256, 300);
		send_pixel(1023, 1023);

		// full-size image turned a quarter, widest strides so the offsets wrap
		set_config(SIZE_W'(MAX_SIZE_DEF), '1, '1, COEF_W'(0), COEF_W'(16384));
		send_pixel(0, 0);
		send_pixel(1023, 0);
		send_pixel(0, 1023);
		send_pixel(1023, 1023);
		send_pixel(512, 512);

		// empty image: nothing is ever inside
		set_config('0, SRC_STRIDE_RST, DEST_STRIDE_RST, ROT_COS_RST, ROT_NEGSIN_RST);
		send_pixel(0, 0);
		send_pixel(5, 7);

		// oversized area clamps, zero strides leave just the column
		set_config('1, '0, '0, COEF_W'(-16384), COEF_W'(-16384));
		send_pixel(0, 0);
		send_pixel(1023, 1023);
		send_pixel(512, 100);

		// 2x2 image scaled by 1.5: corner maps to -0.5, which truncates to 0 and copies
		set_config(SIZE_W'(2), STRIDE_W'(3), STRIDE_W'(5), COEF_W'(24576), COEF_W'(0));
		send_pixel(0, 0);
		send_pixel(1, 1);
		send_pixel(1, 0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config();
			// one phase runs without any sender gap
			steady = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// a sender gap of random length before one pixel in five, idle about a third of all cycles
				if (!steady && $urandom_range(99) < 20)
					idle_cycles($urandom_range(1, 4));
				// hold off mid-phase until the pipeline has emptied
				if (ph == 2 && n == PHASE_ITEMS / 2)
					drain();
				random_pixel();
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
